>>> hdl/bmm_pkg.sv
// Shared types and constants for the boolean matrix multiply core.
// Depends on nothing; every other file imports it.
package bmm_pkg;

  localparam int ROW_W  = 32;
  localparam int IDX_W  = 5;
  localparam int SIZE_W = 6;
  localparam int KIND_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LEFT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // row write bus seen by the left store and by every cell
  typedef struct packed {
    logic             left_we;
    logic             right_we;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] bits;
  } bmm_load_t;

  // one product row travelling down the chain of cells
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic             last;
    logic [ROW_W-1:0] left;
    logic [ROW_W-1:0] acc;
  } bmm_flow_t;

  // status of the row feeder
  typedef struct packed {
    logic              busy;
    logic [SIZE_W-1:0] n;
    logic [ROW_W-1:0]  mask;
  } bmm_stat_t;

endpackage

>>> hdl/bmm_in_if.sv
// Request channel: valid/ready handshake with the load/compute payload.
// Depends on bmm_pkg.
interface bmm_in_if import bmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  row_index;
  logic [ROW_W-1:0]  row_bits;

  modport source (output valid, kind, row_index, row_bits, input ready);
  modport sink   (input valid, kind, row_index, row_bits, output ready);
endinterface

>>> hdl/bmm_out_if.sv
// Result channel: valid/ready handshake carrying one product row.
// Depends on bmm_pkg.
interface bmm_out_if import bmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_row;
  logic [ROW_W-1:0] out_bits;
  logic             last;

  modport source (output valid, out_row, out_bits, last, input ready);
  modport sink   (input valid, out_row, out_bits, last, output ready);
endinterface

>>> hdl/bmm_cell.sv
// One cell of the product chain: holds right row K and folds it into the
// passing accumulator when bit K of the passing left row is set. Depends on bmm_pkg.
module bmm_cell import bmm_pkg::*; #(
  parameter int K = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  bmm_load_t load,
  input  bmm_flow_t flow_in,
  output bmm_flow_t flow_out
);

  logic [ROW_W-1:0] right;
  logic [ROW_W-1:0] acc_next;

  // right row k of the product
  always_ff @(posedge clk) begin
    if (load.right_we && (load.idx == IDX_W'(K))) begin
      right <= load.bits;
    end
  end

  // or in this row when the left element is set
  assign acc_next = flow_in.acc | ({ROW_W{flow_in.left[K]}} & right);

  // pipeline stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_out.valid <= 1'b0;
    end else if (advance) begin
      flow_out.valid <= flow_in.valid;
    end
    if (advance) begin
      flow_out.row  <= flow_in.row;
      flow_out.last <= flow_in.last;
      flow_out.left <= flow_in.left;
      flow_out.acc  <= acc_next;
    end
  end

endmodule

>>> hdl/bmm_feed.sv
// Left row store and row sequencer: on a compute it sends left rows
// 0..N-1 into the head of the cell chain, one per advance. Depends on bmm_pkg.
module bmm_feed import bmm_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              start,
  input  logic [SIZE_W-1:0] size,
  input  bmm_load_t         load,
  output bmm_flow_t         flow,
  output bmm_stat_t         stat
);

  localparam int AW = $clog2(DEPTH);

  logic [ROW_W-1:0]  left_rows [DEPTH];
  logic              head_valid;
  logic [IDX_W-1:0]  head_row;
  logic              head_last;
  logic [ROW_W-1:0]  head_left;
  logic [IDX_W-1:0]  i;
  logic [SIZE_W-1:0] n;
  logic [ROW_W-1:0]  mask;
  logic [ROW_W-1:0]  mask_next;
  logic              next_last;

  // left store, rows beyond the depth are dropped
  always_ff @(posedge clk) begin
    if (load.left_we && ({1'b0, load.idx} < SIZE_W'(DEPTH))) begin
      left_rows[load.idx[AW-1:0]] <= load.bits;
    end
  end

  assign mask_next = ROW_W'((33'd1 << size) - 33'd1);
  assign next_last = (({1'b0, i} + SIZE_W'(1)) == n);

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (start) begin
      head_valid <= 1'b1;
    end else if (head_valid && advance && head_last) begin
      head_valid <= 1'b0;
    end
  end

  // row fetch: row i is read while the row before it sits at the head
  always_ff @(posedge clk) begin
    if (start) begin
      i         <= IDX_W'(1);
      n         <= size;
      mask      <= mask_next;
      head_row  <= '0;
      head_last <= (size == SIZE_W'(1));
      head_left <= left_rows[0] & mask_next;
    end else if (head_valid && advance && !head_last) begin
      i         <= i + IDX_W'(1);
      head_row  <= i;
      head_last <= next_last;
      head_left <= left_rows[i[AW-1:0]] & mask;
    end
  end

  // head of the chain
  always_comb begin
    flow.valid = head_valid;
    flow.row   = head_row;
    flow.last  = head_last;
    flow.left  = head_left;
    flow.acc   = '0;
  end

  assign stat.busy = head_valid;
  assign stat.n    = n;
  assign stat.mask = mask;

endmodule

>>> hdl/boolean_matrix_multiply_core.sv
// Boolean matrix multiply core, top level.
// Depends on bmm_pkg, bmm_in_if, bmm_out_if, bmm_feed and bmm_cell.
//
// Usage: requests arrive on in_chan. Kind 0 writes left row row_index, kind 1
// writes right row row_index, kind 2 computes the product, kind 3 is dropped.
// Loads and dropped requests give no result. A compute
// emits N rows on out_chan in row order, one per cycle unless stalled, last set on
// row N-1; bits at or above N read zero. N is cfg_wdata clamped to 1..min(MAX_DIM,32),
// written with cfg_we while the core is idle.
// Timing: each right row sits in one cell of a chain of D = min(MAX_DIM,32)
// cells; left rows stream through the chain one per cycle while it advances, so the
// first product row appears once it has passed the feeder head register and the
// output registers of all D cells, and the rest follow at the same rate. in_chan.ready
// returns once the last row has reached the output register of cell D-1; that
// row may still wait there.
// Stalls: when out_chan.ready is low with a row waiting, the whole chain holds.
// Reset clears all valid state and sets the size register to 32; stores are
// undefined until written.
module boolean_matrix_multiply_core import bmm_pkg::*; #(
  parameter int MAX_DIM = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  bmm_in_if.sink            in_chan,
  bmm_out_if.source         out_chan
);

  localparam int DEPTH = (MAX_DIM < ROW_W) ? MAX_DIM : ROW_W;

  logic [SIZE_W-1:0] matrix_size;
  logic [SIZE_W-1:0] size_eff;
  logic              accept;
  logic              start;
  logic              advance;
  logic              inflight;
  bmm_load_t         load;
  bmm_stat_t         stat;
  bmm_flow_t         chain [DEPTH+1];

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_W'(32);
    end else if (cfg_we) begin
      matrix_size <= cfg_wdata;
    end
  end

  // clamp to the usable range
  always_comb begin
    priority if (matrix_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (matrix_size > SIZE_W'(DEPTH)) begin
      size_eff = SIZE_W'(DEPTH);
    end else begin
      size_eff = matrix_size;
    end
  end

  // rows still inside the cells, feeder head and output stage excluded
  always_comb begin
    inflight = 1'b0;
    for (int k = 1; k < DEPTH; k++) begin
      inflight = inflight | chain[k].valid;
    end
  end

  // request decode
  assign in_chan.ready = !stat.busy && !inflight;
  assign accept        = in_chan.valid && in_chan.ready;
  assign start         = accept && (in_chan.kind == KIND_COMPUTE);
  assign advance       = !chain[DEPTH].valid || out_chan.ready;

  always_comb begin
    load.left_we  = accept && (in_chan.kind == KIND_LEFT);
    load.right_we = accept && (in_chan.kind == KIND_RIGHT);
    load.idx      = in_chan.row_index;
    load.bits     = in_chan.row_bits;
  end

  bmm_feed #(
    .DEPTH (DEPTH)
  ) u_feed (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .start   (start),
    .size    (size_eff),
    .load    (load),
    .flow    (chain[0]),
    .stat    (stat)
  );

  // chain of cells, one per right row
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    bmm_cell #(
      .K (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .load     (load),
      .flow_in  (chain[k]),
      .flow_out (chain[k+1])
    );
  end

  // output stage is the last cell
  assign out_chan.valid    = chain[DEPTH].valid;
  assign out_chan.out_row  = chain[DEPTH].row;
  assign out_chan.out_bits = chain[DEPTH].acc & stat.mask;
  assign out_chan.last     = chain[DEPTH].last;

  // a compute locks out further requests
  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_chan.ready)
    else $error("request accepted right after a compute");

  // the final row is row N-1
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && out_chan.last) |-> ({1'b0, out_chan.out_row} == stat.n - SIZE_W'(1)))
    else $error("last flag on wrong row");

  // product rows leave in order without gaps
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && out_chan.ready && !out_chan.last) |=>
      (out_chan.valid && (out_chan.out_row == IDX_W'($past(out_chan.out_row) + IDX_W'(1)))))
    else $error("product row out of order");

endmodule

>>> sim/boolean_matrix_multiply_core_test.sv
// Self-checking bench for the boolean matrix multiply core: directed table, then random
// load/compute phases at several matrix sizes, each product row checked in order.
// Depends on bmm_pkg, bmm_in_if, bmm_out_if and boolean_matrix_multiply_core.
module boolean_matrix_multiply_core_test import bmm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM       = 32;
  localparam int CLK_PERIOD    = 4;
  localparam int ITEM_TARGET   = 330;
  localparam int CALM_AFTER    = 280;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 200;
  localparam int MAX_SHOWN     = 10;
  localparam int TIMEOUT_NS    = 4_000_000;

  // kind 3 is dropped by the core
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one expected product row
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [ROW_W-1:0] bits;
    logic             last;
  } product_row_t;

  // one step of the directed plan: either a size write or a request
  typedef struct packed {
    logic              is_size;
    logic [SIZE_W-1:0] size;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [ROW_W-1:0]  bits;
    logic              typed;
    logic [ROW_W-1:0]  want;
  } drill_step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  bmm_in_if  in_chan ();
  bmm_out_if out_chan ();

  boolean_matrix_multiply_core #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // bench copy of the two stores and the size register
  logic [ROW_W-1:0]  left_store [MAX_DIM];
  logic [ROW_W-1:0]  right_store [MAX_DIM];
  bit                left_set [MAX_DIM];
  bit                right_set [MAX_DIM];
  logic [SIZE_W-1:0] size_reg = 6'd32;

  product_row_t expected_rows [$];

  int unsigned mismatches, rows_checked, loads_sent, computes_sent, dropped_sent;
  int unsigned size_writes, items_sent;
  bit          idle_gaps = 1'b1;
  bit          ready_stalls = 1'b1;
  bit          hold_request = 1'b0;

  // directed plan: small sizes, masking of high bits, dropped kind, size clamp at zero
  drill_step_t directed_plan [0:21] = '{
    '{1'b1, 6'd1, KIND_LEFT,    5'd0,  32'h0,        1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_LEFT,    5'd0,  32'hFFFFFFFF, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_RIGHT,   5'd0,  32'hFFFFFFFF, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_COMPUTE, 5'd31, 32'hFFFFFFFF, 1'b1, 32'h1},
    '{1'b0, 6'd0, KIND_LEFT,    5'd0,  32'hFFFFFFFE, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_COMPUTE, 5'd0,  32'h0,        1'b1, 32'h0},
    '{1'b0, 6'd0, KIND_LEFT,    5'd31, 32'hFFFFFFFF, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_UNUSED,  5'd5,  32'hA5A5A5A5, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_LEFT,    5'd0,  32'h00000001, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_RIGHT,   5'd0,  32'hFFFFFFFE, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_COMPUTE, 5'd17, 32'h5A5A5A5A, 1'b1, 32'h0},
    '{1'b1, 6'd0, KIND_LEFT,    5'd0,  32'h0,        1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_RIGHT,   5'd0,  32'h00000001, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_COMPUTE, 5'd0,  32'h0,        1'b1, 32'h1},
    '{1'b1, 6'd3, KIND_LEFT,    5'd0,  32'h0,        1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_LEFT,    5'd1,  32'h00000006, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_LEFT,    5'd2,  32'hFFFFFFF8, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_RIGHT,   5'd1,  32'h00000005, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_RIGHT,   5'd2,  32'h80000003, 1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_COMPUTE, 5'd0,  32'h0,        1'b0, 32'h0},
    '{1'b1, 6'd2, KIND_LEFT,    5'd0,  32'h0,        1'b0, 32'h0},
    '{1'b0, 6'd0, KIND_COMPUTE, 5'd9,  32'h12345678, 1'b0, 32'h0}
  };

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // overall time limit
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d product rows still expected", expected_rows.size());
    $display("*** FAILED ***");
    $finish;
  end

  // size actually used: clamped to 1..min(MAX_DIM,32)
  function automatic int unsigned effective_size(logic [SIZE_W-1:0] v);
    int unsigned cap;
    int unsigned n;
    cap = (MAX_DIM < 32) ? MAX_DIM : 32;
    n = (v == 0) ? 1 : v;
    if (n > cap) n = cap;
    return n;
  endfunction

  // true when rows 0..n-1 of both stores hold written data
  function automatic bit stores_ready(int unsigned n);
    for (int unsigned r = 0; r < n; r++)
      if (!left_set[r] || !right_set[r]) return 1'b0;
    return 1'b1;
  endfunction

  // or-of-ands product of the current stores, one entry per row
  function automatic void predict_product();
    int unsigned      n;
    logic [63:0]      wide;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] lrow;
    logic [ROW_W-1:0] acc;
    n = effective_size(size_reg);
    wide = (64'd1 << n) - 64'd1;
    mask = wide[ROW_W-1:0];
    for (int unsigned i = 0; i < n; i++) begin
      lrow = left_store[i] & mask;
      acc = '0;
      for (int unsigned k = 0; k < n; k++)
        if (lrow[k]) acc |= right_store[k];
      expected_rows.push_back('{row: IDX_W'(i), bits: acc & mask, last: (i + 1 == n)});
    end
  endfunction

  // bench state update for one accepted request
  function automatic void apply_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                        logic [ROW_W-1:0] bits);
    case (kind)
      KIND_LEFT: begin
        if (idx < MAX_DIM) begin
          left_store[idx] = bits;
          left_set[idx] = 1'b1;
        end
      end
      KIND_RIGHT: begin
        if (idx < MAX_DIM) begin
          right_store[idx] = bits;
          right_set[idx] = 1'b1;
        end
      end
      KIND_COMPUTE: predict_product();
      default: ;
    endcase
  endfunction

  // row contents: zero, all ones, sparse or dense
  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("mismatch: %s", msg);
  endfunction

  // offer one request and wait until it is taken
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                              input logic [ROW_W-1:0] bits, input bit typed = 1'b0,
                              input logic [ROW_W-1:0] want = '0);
    int unsigned gap;
    if (idle_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.kind      <= kind;
    in_chan.row_index <= idx;
    in_chan.row_bits  <= bits;
    do @(posedge clk); while (!in_chan.ready);
    if (typed) expected_rows.push_back('{row: '0, bits: want, last: 1'b1});
    else apply_request(kind, idx, bits);
    case (kind)
      KIND_LEFT, KIND_RIGHT: loads_sent++;
      KIND_COMPUTE: computes_sent++;
      default: dropped_sent++;
    endcase
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // stop offering, let every product row drain and the core settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_matrix_size(input logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_reg = v;
    size_writes++;
  endtask

  // stray requests: dropped kind, loads outside the active size (any row at size 32), early compute
  task automatic send_noise(input int unsigned n);
    case ($urandom_range(0, 2))
      0: send_request(KIND_UNUSED, IDX_W'($urandom), $urandom);
      1: send_request($urandom_range(0, 1) ? KIND_LEFT : KIND_RIGHT,
                      IDX_W'($urandom_range((n < 32) ? n : 0, 31)), random_row());
      default: begin
        if (stores_ready(n)) send_request(KIND_COMPUTE, IDX_W'($urandom), $urandom);
        else send_request(KIND_UNUSED, IDX_W'($urandom), $urandom);
      end
    endcase
  endtask

  // result ready: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned span;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (ready_stalls && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 17);
        out_chan.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end else begin
        span = $urandom_range(1, 24);
        out_chan.ready <= 1'b1;
        repeat (span) @(posedge clk);
      end
    end
  end

  // compare each product row against the oldest expected one
  always @(posedge clk) begin
    product_row_t want;
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (expected_rows.size() == 0) begin
        flag_mismatch($sformatf("unexpected row %0d bits %h last %b",
                                out_chan.out_row, out_chan.out_bits, out_chan.last));
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (out_chan.out_row !== want.row || out_chan.out_bits !== want.bits ||
            out_chan.last !== want.last)
          flag_mismatch($sformatf("expected row %0d bits %h last %b, got row %0d bits %h last %b",
                                  want.row, want.bits, want.last, out_chan.out_row,
                                  out_chan.out_bits, out_chan.last));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned       phase;
    int unsigned       n;
    int unsigned       rounds;
    bit                partial;
    logic [SIZE_W-1:0] size;

    in_chan.valid     <= 1'b0;
    in_chan.kind      <= KIND_LEFT;
    in_chan.row_index <= '0;
    in_chan.row_bits  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed plan
    foreach (directed_plan[s]) begin
      if (directed_plan[s].is_size)
        set_matrix_size(directed_plan[s].size);
      else
        send_request(directed_plan[s].kind, directed_plan[s].idx, directed_plan[s].bits,
                     directed_plan[s].typed, directed_plan[s].want);
    end

    // random phases: load both matrices, then compute
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_AFTER) begin
        idle_gaps = 1'b0;
        ready_stalls = 1'b0;
      end
      if (phase == 0) size = 6'd63;
      else if (phase == 2) size = 6'd16;
      else if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: size = 6'd0;
          1: size = 6'd32;
          2: size = 6'd33;
          default: size = 6'd63;
        endcase
      end else size = SIZE_W'($urandom_range(1, 8));
      set_matrix_size(size);
      n = effective_size(size);
      rounds = $urandom_range(1, 2);
      for (int unsigned rd = 0; rd < rounds; rd++) begin
        // a partial reload leaves some earlier rows in place
        partial = stores_ready(n) && $urandom_range(0, 3) == 0;
        for (int unsigned r = 0; r < n; r++) begin
          if (!partial || $urandom_range(0, 1))
            send_request(KIND_LEFT, IDX_W'(r), random_row());
          if ($urandom_range(0, 7) == 0) send_noise(n);
          if (!partial || $urandom_range(0, 1))
            send_request(KIND_RIGHT, IDX_W'(r), random_row());
        end
        // long result hold-off while computes pile up at the input
        if (phase == 2 && rd == 0) begin
          in_chan.valid <= 1'b0;
          hold_request = 1'b1;
          wait (!hold_request);
          send_request(KIND_COMPUTE, IDX_W'($urandom), $urandom);
          send_request(KIND_COMPUTE, IDX_W'($urandom), $urandom);
          send_request(KIND_LEFT, IDX_W'($urandom_range(0, n - 1)), random_row());
        end
        send_request(KIND_COMPUTE, IDX_W'($urandom), $urandom);
        if ($urandom_range(0, 3) == 0) send_request(KIND_COMPUTE, IDX_W'($urandom), $urandom);
        if (phase == 1 || $urandom_range(0, 4) == 0) wait_idle();
      end
      phase++;
    end

    idle_gaps = 1'b0;
    ready_stalls = 1'b0;
    wait_idle();
    $display("sent %0d loads, %0d computes, %0d dropped requests across %0d size writes",
             loads_sent, computes_sent, dropped_sent, size_writes);
    $display("compared %0d product rows, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
